FILE: src/pcc_pkg.sv
// shared constants and types for the permutation compose and cycle block
`default_nettype none

package pcc_pkg;

    localparam int MAX_SIZE_DEF = 16;
    localparam int MAX_RESULTS  = 16;

    localparam int OP_W   = 3;
    localparam int FIELD_W = 5;
    localparam int SIZE_W = 5;
    localparam logic [SIZE_W-1:0] SIZE_RST = 5'd16;

    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_WR_MAIN = 3'd0,
        OP_WR_OPND = 3'd1,
        OP_COMP_L  = 3'd2,
        OP_COMP_R  = 3'd3,
        OP_CYCLES  = 3'd4,
        OP_RD_MAIN = 3'd5
    } op_t;

    localparam logic STS_OK  = 1'b0;
    localparam logic STS_ERR = 1'b1;

endpackage

`default_nettype wire

FILE: src/permutation_compose_and_cycles.sv
// permutation store with composition and cycle decomposition, memory based
// writes and unknown opcodes go straight to the emit state; reads pass through a read state first
// left compose: main is first copied to scratch, then for each entry an operand read, a scratch read
// and a write back follow; right compose reads main, then the operand entry it names, and writes that back
// one request at a time; the single read port of the main store sets the pace
// reset: synchronous active low, both permutations read as identity through per-entry written flags
`default_nettype none

module permutation_compose_and_cycles #(
    parameter int MAX_SIZE = pcc_pkg::MAX_SIZE_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // configuration: size_in_use
    input  wire logic                            cfg_wr_en,
    input  wire logic [pcc_pkg::SIZE_W-1:0]      cfg_wr_data,
    // request: opcode [2:0], index [7:3], value [12:8], zero above
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    input  wire logic [pcc_pkg::S_TDATA_W-1:0]   s_tdata,
    // result: status [0], data [5:1], zero above
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    output logic [pcc_pkg::M_TDATA_W-1:0]        m_tdata,
    output logic                                 m_tlast
);

    localparam int IW    = $clog2(MAX_SIZE);
    localparam int EW    = $clog2(MAX_SIZE + 1);
    localparam int CW    = (EW > pcc_pkg::FIELD_W) ? EW : pcc_pkg::FIELD_W;
    localparam int CNT_W = $clog2(pcc_pkg::MAX_RESULTS + 1);
    localparam int FW    = pcc_pkg::FIELD_W;

    typedef enum logic [3:0] {
        ST_IDLE, ST_RD, ST_EMIT, ST_COPY, ST_LC_B, ST_LC_S, ST_LC_W,
        ST_RC_A, ST_RC_B, ST_RC_W, ST_SCAN, ST_WALK, ST_DONE, ST_END
    } state_t;

    // control registers
    state_t                state_reg, state_next;
    logic [pcc_pkg::SIZE_W-1:0] size_reg;
    logic [EW-1:0]         j_reg, j_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  pend_reg, pend_next;
    logic [MAX_SIZE-1:0]   visited_reg, visited_next;
    logic [MAX_SIZE-1:0]   main_vld_reg, main_vld_next;
    logic [MAX_SIZE-1:0]   opnd_vld_reg, opnd_vld_next;
    logic                  out_vld_reg, out_vld_next;
    logic                  cp_pend_reg, cp_pend_next;

    // payload registers
    logic [EW-1:0]         len_reg, len_next;
    logic [EW-1:0]         pend_len_reg, pend_len_next;
    logic                  res_sts_reg, res_sts_next;
    logic [FW-1:0]         res_data_reg, res_data_next;
    logic                  out_sts_reg, out_sts_next;
    logic [FW-1:0]         out_data_reg, out_data_next;
    logic                  out_last_reg, out_last_next;
    logic [IW-1:0]         cp_addr_reg, cp_addr_next;

    // memories and their read side
    logic [EW-1:0]         main_mem [MAX_SIZE];
    logic [EW-1:0]         opnd_mem [MAX_SIZE];
    logic [EW-1:0]         scr_mem  [MAX_SIZE];
    logic [EW-1:0]         main_q_reg, opnd_q_reg, scr_q_reg;
    logic                  main_q_vld_reg, opnd_q_vld_reg;
    logic [IW-1:0]         main_q_addr_reg, opnd_q_addr_reg;
    logic [IW-1:0]         main_ra, opnd_ra, scr_ra;
    logic                  main_we, opnd_we;
    logic [IW-1:0]         main_wa, opnd_wa;
    logic [EW-1:0]         main_wd, opnd_wd;

    // decoded request
    pcc_pkg::op_t          s_op;
    logic [FW-1:0]         s_index, s_value;
    logic [CW-1:0]         idx_ext, val_ext, n_ext, idx_m1;
    logic [IW-1:0]         idx_addr;
    logic                  idx_ok, val_ok;

    logic [CW-1:0]         size_ext;
    logic [EW-1:0]         n_eff;
    logic [EW-1:0]         main_rd, opnd_rd, p_val, p_m1;
    logic [CW-1:0]         rd_ext, plen_ext;
    logic [IW-1:0]         p_idx, j_idx;
    logic                  p_ok, j_last, out_free, s_acc;
    logic [CNT_W-1:0]      cnt_inc;

    // effective size: saturate to the store depth, zero counts as one
    assign size_ext = CW'(size_reg);
    always_comb begin
        if (size_reg == '0) begin
            n_eff = EW'(1);
        end else if (size_ext > CW'(MAX_SIZE)) begin
            n_eff = EW'(MAX_SIZE);
        end else begin
            n_eff = EW'(size_ext);
        end
    end

    assign s_op    = pcc_pkg::op_t'(s_tdata[2:0]);
    assign s_index = s_tdata[7:3];
    assign s_value = s_tdata[12:8];
    assign idx_ext = CW'(s_index);
    assign val_ext = CW'(s_value);
    assign n_ext   = CW'(n_eff);
    assign idx_m1  = idx_ext - CW'(1);
    assign idx_addr = idx_m1[IW-1:0];
    assign idx_ok  = (s_index != '0) && (idx_ext <= n_ext);
    assign val_ok  = (s_value != '0) && (val_ext <= n_ext);

    // unwritten entries read as identity
    assign main_rd = main_q_vld_reg ? main_q_reg : EW'(main_q_addr_reg) + EW'(1);
    assign opnd_rd = opnd_q_vld_reg ? opnd_q_reg : EW'(opnd_q_addr_reg) + EW'(1);

    assign rd_ext   = CW'(main_rd);
    assign plen_ext = CW'(pend_len_reg);

    assign p_val  = (state_reg == ST_LC_S) ? opnd_rd : main_rd;
    assign p_m1   = p_val - EW'(1);
    assign p_idx  = p_m1[IW-1:0];
    assign p_ok   = (p_val != '0) && (p_val <= n_eff);
    assign j_idx  = j_reg[IW-1:0];
    assign j_last = (j_reg == n_eff - EW'(1));
    assign cnt_inc = cnt_reg + CNT_W'(1);

    assign s_tready = (state_reg == ST_IDLE);
    assign s_acc    = s_tvalid && s_tready;
    assign out_free = !out_vld_reg || m_tready;

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {{(pcc_pkg::M_TDATA_W - FW - 1){1'b0}}, out_data_reg, out_sts_reg};
    assign m_tlast  = out_last_reg;

    always_comb begin
        state_next    = state_reg;
        j_next        = j_reg;
        cnt_next      = cnt_reg;
        pend_next     = pend_reg;
        visited_next  = visited_reg;
        main_vld_next = main_vld_reg;
        opnd_vld_next = opnd_vld_reg;
        out_vld_next  = out_vld_reg;
        cp_pend_next  = 1'b0;
        len_next      = len_reg;
        pend_len_next = pend_len_reg;
        res_sts_next  = res_sts_reg;
        res_data_next = res_data_reg;
        out_sts_next  = out_sts_reg;
        out_data_next = out_data_reg;
        out_last_next = out_last_reg;
        cp_addr_next  = cp_addr_reg;
        main_ra = '0;
        opnd_ra = '0;
        scr_ra  = '0;
        main_we = 1'b0;
        main_wa = '0;
        main_wd = '0;
        opnd_we = 1'b0;
        opnd_wa = '0;
        opnd_wd = '0;

        if (out_vld_reg && m_tready) begin
            out_vld_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_acc) begin
                    res_data_next = '0;
                    res_sts_next  = pcc_pkg::STS_OK;
                    j_next        = '0;
                    case (s_op)
                        pcc_pkg::OP_WR_MAIN, pcc_pkg::OP_WR_OPND: begin
                            if (idx_ok && val_ok) begin
                                if (s_op == pcc_pkg::OP_WR_MAIN) begin
                                    main_we = 1'b1;
                                    main_wa = idx_addr;
                                    main_wd = EW'(val_ext);
                                    main_vld_next[idx_addr] = 1'b1;
                                end else begin
                                    opnd_we = 1'b1;
                                    opnd_wa = idx_addr;
                                    opnd_wd = EW'(val_ext);
                                    opnd_vld_next[idx_addr] = 1'b1;
                                end
                            end else begin
                                res_sts_next = pcc_pkg::STS_ERR;
                            end
                            state_next = ST_EMIT;
                        end
                        pcc_pkg::OP_RD_MAIN: begin
                            if (idx_ok) begin
                                main_ra    = idx_addr;
                                state_next = ST_RD;
                            end else begin
                                res_sts_next = pcc_pkg::STS_ERR;
                                state_next   = ST_EMIT;
                            end
                        end
                        pcc_pkg::OP_COMP_L: state_next = ST_COPY;
                        pcc_pkg::OP_COMP_R: state_next = ST_RC_A;
                        pcc_pkg::OP_CYCLES: begin
                            visited_next = '0;
                            cnt_next     = '0;
                            pend_next    = 1'b0;
                            state_next   = ST_SCAN;
                        end
                        default: begin
                            res_sts_next = pcc_pkg::STS_ERR;
                            state_next   = ST_EMIT;
                        end
                    endcase
                end
            end
            ST_RD: begin
                res_data_next = rd_ext[FW-1:0];
                state_next    = ST_EMIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_sts_next  = res_sts_reg;
                    out_data_next = res_data_reg;
                    out_last_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            // snapshot of the main store, each entry written in the cycle after its read
            ST_COPY: begin
                main_ra      = j_idx;
                cp_pend_next = 1'b1;
                cp_addr_next = j_idx;
                if (j_last) begin
                    j_next     = '0;
                    state_next = ST_LC_B;
                end else begin
                    j_next = j_reg + EW'(1);
                end
            end
            ST_LC_B: begin
                opnd_ra    = j_idx;
                state_next = ST_LC_S;
            end
            ST_LC_S: begin
                scr_ra     = p_ok ? p_idx : j_idx;
                state_next = ST_LC_W;
            end
            ST_LC_W: begin
                main_we = 1'b1;
                main_wa = j_idx;
                main_wd = scr_q_reg;
                main_vld_next[j_idx] = 1'b1;
                if (j_last) begin
                    state_next = ST_EMIT;
                end else begin
                    j_next     = j_reg + EW'(1);
                    state_next = ST_LC_B;
                end
            end
            ST_RC_A: begin
                main_ra    = j_idx;
                state_next = ST_RC_B;
            end
            ST_RC_B: begin
                if (p_ok) begin
                    opnd_ra    = p_idx;
                    state_next = ST_RC_W;
                end else if (j_last) begin
                    state_next = ST_EMIT;
                end else begin
                    j_next     = j_reg + EW'(1);
                    state_next = ST_RC_A;
                end
            end
            ST_RC_W: begin
                main_we = 1'b1;
                main_wa = j_idx;
                main_wd = opnd_rd;
                main_vld_next[j_idx] = 1'b1;
                if (j_last) begin
                    state_next = ST_EMIT;
                end else begin
                    j_next     = j_reg + EW'(1);
                    state_next = ST_RC_A;
                end
            end
            ST_SCAN: begin
                if (j_reg == n_eff) begin
                    state_next = ST_END;
                end else if (visited_reg[j_idx]) begin
                    j_next = j_reg + EW'(1);
                end else begin
                    main_ra    = j_idx;
                    len_next   = '0;
                    state_next = ST_WALK;
                end
            end
            // out-of-range successor ends the walk like a visited one
            ST_WALK: begin
                if (p_ok && !visited_reg[p_idx]) begin
                    visited_next[p_idx] = 1'b1;
                    main_ra  = p_idx;
                    len_next = len_reg + EW'(1);
                end else begin
                    state_next = ST_DONE;
                end
            end
            // hold one length back so the final one can carry tlast
            ST_DONE: begin
                if (!pend_reg || out_free) begin
                    if (pend_reg) begin
                        out_vld_next  = 1'b1;
                        out_sts_next  = pcc_pkg::STS_OK;
                        out_data_next = plen_ext[FW-1:0];
                        out_last_next = 1'b0;
                    end
                    pend_next     = 1'b1;
                    pend_len_next = len_reg;
                    cnt_next      = cnt_inc;
                    if (cnt_inc == CNT_W'(pcc_pkg::MAX_RESULTS)) begin
                        state_next = ST_END;
                    end else begin
                        j_next     = j_reg + EW'(1);
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_END: begin
                if (out_free) begin
                    out_vld_next  = 1'b1;
                    out_sts_next  = pcc_pkg::STS_OK;
                    out_data_next = plen_ext[FW-1:0];
                    out_last_next = 1'b1;
                    pend_next     = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            size_reg     <= pcc_pkg::SIZE_RST;
            j_reg        <= '0;
            cnt_reg      <= '0;
            pend_reg     <= 1'b0;
            visited_reg  <= '0;
            main_vld_reg <= '0;
            opnd_vld_reg <= '0;
            out_vld_reg  <= 1'b0;
            cp_pend_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            if (cfg_wr_en) begin
                size_reg <= cfg_wr_data;
            end
            j_reg        <= j_next;
            cnt_reg      <= cnt_next;
            pend_reg     <= pend_next;
            visited_reg  <= visited_next;
            main_vld_reg <= main_vld_next;
            opnd_vld_reg <= opnd_vld_next;
            out_vld_reg  <= out_vld_next;
            cp_pend_reg  <= cp_pend_next;
        end
        len_reg      <= len_next;
        pend_len_reg <= pend_len_next;
        res_sts_reg  <= res_sts_next;
        res_data_reg <= res_data_next;
        out_sts_reg  <= out_sts_next;
        out_data_reg <= out_data_next;
        out_last_reg <= out_last_next;
        cp_addr_reg  <= cp_addr_next;
    end

    always_ff @(posedge aclk) begin
        if (main_we) begin
            main_mem[main_wa] <= main_wd;
        end
        main_q_reg      <= main_mem[main_ra];
        main_q_vld_reg  <= main_vld_reg[main_ra];
        main_q_addr_reg <= main_ra;
    end

    always_ff @(posedge aclk) begin
        if (opnd_we) begin
            opnd_mem[opnd_wa] <= opnd_wd;
        end
        opnd_q_reg      <= opnd_mem[opnd_ra];
        opnd_q_vld_reg  <= opnd_vld_reg[opnd_ra];
        opnd_q_addr_reg <= opnd_ra;
    end

    always_ff @(posedge aclk) begin
        if (cp_pend_reg) begin
            scr_mem[cp_addr_reg] <= main_rd;
        end
        scr_q_reg <= scr_mem[scr_ra];
    end

    a_visited_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_op == pcc_pkg::OP_CYCLES) |=> (visited_reg == '0))
        else $error("visited map not cleared at start of decomposition");

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_W'(pcc_pkg::MAX_RESULTS))
        else $error("result count beyond limit");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> (len_reg <= n_eff))
        else $error("cycle length beyond effective size");

    a_idle_no_pend: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> !pend_reg)
        else $error("decomposition result left pending");

    a_write_marks: assert property (@(posedge aclk) disable iff (!aresetn)
        main_we |=> main_vld_reg[$past(main_wa)])
        else $error("main entry written but not flagged");

endmodule

`default_nettype wire

FILE: bench/tb_permutation_compose_and_cycles.sv
// testbench for the permutation compose and cycle decomposition block
`default_nettype none

module tb_permutation_compose_and_cycles;

    localparam logic [pcc_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
    localparam logic [pcc_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;
    localparam int LONG_HOLD = 300;

    typedef struct packed {
        logic                        status;
        logic [pcc_pkg::FIELD_W-1:0] data;
        logic                        last;
    } perm_result_t;

    logic                          aclk        = 1'b0;
    logic                          aresetn     = 1'b0;
    logic                          cfg_wr_en   = 1'b0;
    logic [pcc_pkg::SIZE_W-1:0]    cfg_wr_data = '0;
    logic                          s_tvalid    = 1'b0;
    logic                          s_tready;
    logic [pcc_pkg::S_TDATA_W-1:0] s_tdata     = '0;
    logic                          m_tvalid;
    logic                          m_tready    = 1'b0;
    logic [pcc_pkg::M_TDATA_W-1:0] m_tdata;
    logic                          m_tlast;

    // own copy of both permutations and the size register
    logic [pcc_pkg::FIELD_W-1:0] main_model    [pcc_pkg::MAX_SIZE_DEF];
    logic [pcc_pkg::FIELD_W-1:0] operand_model [pcc_pkg::MAX_SIZE_DEF];
    logic [pcc_pkg::SIZE_W-1:0]  size_model;

    perm_result_t perm_results [$];
    int  failures      = 0;
    bit  sender_idling = 1'b1;
    bit  sink_idling   = 1'b1;
    bit  hold_pending  = 1'b0;

    permutation_compose_and_cycles dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),     // opcode, index, value, zero above
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),     // status, data, zero above
        .m_tlast     (m_tlast)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bit fits(input int v, input int n);
        return v >= 1 && v <= n;
    endfunction

    function automatic int active_size();
        if (size_model > pcc_pkg::MAX_SIZE_DEF) return pcc_pkg::MAX_SIZE_DEF;
        if (size_model < 1) return 1;
        return size_model;
    endfunction

    task automatic push_result(input logic status, input int data, input logic last);
        perm_result_t r;
        r.status = status;
        r.data   = pcc_pkg::FIELD_W'(data);
        r.last   = last;
        perm_results = {perm_results, r};
    endtask

    task automatic apply_perm_op(input logic [pcc_pkg::OP_W-1:0] op,
                                 input logic [pcc_pkg::FIELD_W-1:0] idx,
                                 input logic [pcc_pkg::FIELD_W-1:0] val);
        logic [pcc_pkg::FIELD_W-1:0] snapshot [pcc_pkg::MAX_SIZE_DEF];
        bit                          seen     [pcc_pkg::MAX_SIZE_DEF];
        int n, i, p, len, count;
        n = active_size();
        case (op)
            pcc_pkg::OP_WR_MAIN, pcc_pkg::OP_WR_OPND: begin
                if (!fits(idx, n) || !fits(val, n)) begin
                    push_result(pcc_pkg::STS_ERR, 0, 1'b1);
                end else begin
                    if (op == pcc_pkg::OP_WR_MAIN) main_model[idx-1] = val;
                    else operand_model[idx-1] = val;
                    push_result(pcc_pkg::STS_OK, 0, 1'b1);
                end
            end
            pcc_pkg::OP_COMP_L, pcc_pkg::OP_COMP_R: begin
                for (i = 0; i < pcc_pkg::MAX_SIZE_DEF; i++) snapshot[i] = main_model[i];
                for (i = 0; i < n; i++) begin
                    if (op == pcc_pkg::OP_COMP_L) begin
                        p = operand_model[i];
                        main_model[i] = fits(p, n) ? snapshot[p-1] : snapshot[i];
                    end else begin
                        p = snapshot[i];
                        if (fits(p, n)) main_model[i] = operand_model[p-1];
                    end
                end
                push_result(pcc_pkg::STS_OK, 0, 1'b1);
            end
            pcc_pkg::OP_CYCLES: begin
                for (i = 0; i < pcc_pkg::MAX_SIZE_DEF; i++) seen[i] = 1'b0;
                count = 0;
                for (i = 0; i < n && count < pcc_pkg::MAX_RESULTS; i++) begin
                    if (!seen[i]) begin
                        len = 0;
                        p = main_model[i];
                        // an out-of-range successor ends the walk like a visited one
                        while (fits(p, n) && !seen[p-1]) begin
                            seen[p-1] = 1'b1;
                            p = main_model[p-1];
                            len++;
                        end
                        push_result(pcc_pkg::STS_OK, len, 1'b0);
                        count++;
                    end
                end
                perm_results[perm_results.size() - 1].last = 1'b1;
            end
            pcc_pkg::OP_RD_MAIN: begin
                if (!fits(idx, n)) push_result(pcc_pkg::STS_ERR, 0, 1'b1);
                else push_result(pcc_pkg::STS_OK, main_model[idx-1], 1'b1);
            end
            default: push_result(pcc_pkg::STS_ERR, 0, 1'b1);
        endcase
    endtask

    // valid is left high on return; the next call or a drain follows in the same step
    task automatic send_request(input logic [pcc_pkg::OP_W-1:0] op,
                                input logic [pcc_pkg::FIELD_W-1:0] idx,
                                input logic [pcc_pkg::FIELD_W-1:0] val);
        if (sender_idling && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, val, idx, op};
        do @(posedge aclk); while (!s_tready);
        apply_perm_op(op, idx, val);
    endtask

    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (perm_results.size() != 0) @(posedge aclk);
    endtask

    task automatic set_size(input logic [pcc_pkg::SIZE_W-1:0] v);
        wait_for_results();
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        size_model = v;
    endtask

    function automatic logic [pcc_pkg::FIELD_W-1:0] pick_position(input int n);
        if ($urandom_range(0, 99) < 85) return pcc_pkg::FIELD_W'($urandom_range(1, n));
        return pcc_pkg::FIELD_W'($urandom_range(0, pcc_pkg::MAX_SIZE_DEF));
    endfunction

    // identity after reset, out-of-range read, full cycle list capped at sixteen
    task automatic test_reset_state();
        send_request(pcc_pkg::OP_RD_MAIN, 5'd1, 5'd0);
        send_request(pcc_pkg::OP_RD_MAIN, 5'd16, 5'd31);
        send_request(pcc_pkg::OP_RD_MAIN, 5'd0, 5'd0);
        send_request(pcc_pkg::OP_CYCLES, 5'd0, 5'd0);
        wait_for_results();
    endtask

    task automatic test_rejected_writes();
        send_request(pcc_pkg::OP_WR_MAIN, 5'd1, 5'd0);
        send_request(pcc_pkg::OP_WR_OPND, 5'd16, 5'd16);
        send_request(pcc_pkg::OP_WR_OPND, 5'd0, 5'd3);
        send_request(OP_UNUSED_6, 5'd31, 5'd31);
        send_request(OP_UNUSED_7, 5'd2, 5'd2);
        wait_for_results();
    endtask

    task automatic test_compose();
        send_request(pcc_pkg::OP_WR_MAIN, 5'd1, 5'd2);
        send_request(pcc_pkg::OP_WR_MAIN, 5'd2, 5'd1);
        send_request(pcc_pkg::OP_WR_OPND, 5'd2, 5'd3);
        send_request(pcc_pkg::OP_WR_OPND, 5'd3, 5'd2);
        send_request(pcc_pkg::OP_COMP_L, 5'd0, 5'd0);
        send_request(pcc_pkg::OP_COMP_R, 5'd0, 5'd0);
        send_request(pcc_pkg::OP_RD_MAIN, 5'd2, 5'd0);
        send_request(pcc_pkg::OP_CYCLES, 5'd0, 5'd0);
        wait_for_results();
    endtask

    // entries left above the size after it is lowered, and maps that are not permutations
    task automatic test_stale_and_broken();
        send_request(pcc_pkg::OP_WR_MAIN, 5'd1, 5'd16);
        set_size(5'd2);
        send_request(pcc_pkg::OP_RD_MAIN, 5'd1, 5'd0);
        send_request(pcc_pkg::OP_CYCLES, 5'd0, 5'd0);
        send_request(pcc_pkg::OP_COMP_L, 5'd0, 5'd0);
        send_request(pcc_pkg::OP_COMP_R, 5'd0, 5'd0);
        set_size(5'd3);
        send_request(pcc_pkg::OP_WR_MAIN, 5'd1, 5'd2);
        send_request(pcc_pkg::OP_WR_MAIN, 5'd3, 5'd2);
        send_request(pcc_pkg::OP_CYCLES, 5'd0, 5'd0);
        wait_for_results();
    endtask

    task automatic random_requests(input int count);
        int k, sel, a, b, n;
        logic [pcc_pkg::FIELD_W-1:0] va, vb;
        n = active_size();
        for (k = 0; k < count; k++) begin
            sel = $urandom_range(0, 99);
            a = $urandom_range(1, n);
            b = $urandom_range(1, n);
            if (sel < 15) begin
                // a swap keeps a permutation a permutation
                va = main_model[a-1];
                vb = main_model[b-1];
                send_request(pcc_pkg::OP_WR_MAIN, pcc_pkg::FIELD_W'(a), vb);
                send_request(pcc_pkg::OP_WR_MAIN, pcc_pkg::FIELD_W'(b), va);
            end else if (sel < 28) begin
                va = operand_model[a-1];
                vb = operand_model[b-1];
                send_request(pcc_pkg::OP_WR_OPND, pcc_pkg::FIELD_W'(a), vb);
                send_request(pcc_pkg::OP_WR_OPND, pcc_pkg::FIELD_W'(b), va);
            end else if (sel < 42) begin
                send_request($urandom_range(0, 1) ? pcc_pkg::OP_WR_MAIN : pcc_pkg::OP_WR_OPND,
                             pick_position(n), pick_position(n));
            end else if (sel < 56) begin
                send_request(pcc_pkg::OP_RD_MAIN, pick_position(n),
                             pcc_pkg::FIELD_W'($urandom_range(0, 16)));
            end else if (sel < 69) begin
                send_request(pcc_pkg::OP_COMP_L, pcc_pkg::FIELD_W'($urandom_range(0, 16)),
                             5'd0);
            end else if (sel < 82) begin
                send_request(pcc_pkg::OP_COMP_R, 5'd0,
                             pcc_pkg::FIELD_W'($urandom_range(0, 16)));
            end else if (sel < 96) begin
                send_request(pcc_pkg::OP_CYCLES, 5'd0, 5'd0);
            end else begin
                send_request($urandom_range(0, 1) ? OP_UNUSED_6 : OP_UNUSED_7,
                             pcc_pkg::FIELD_W'($urandom_range(0, 16)),
                             pcc_pkg::FIELD_W'($urandom_range(0, 16)));
            end
        end
    endtask

    task automatic test_random_sizes();
        set_size(5'd16);
        random_requests(12);
        set_size(5'd1);
        random_requests(7);
        set_size(5'd2);
        random_requests(8);
        set_size(5'd13);
        random_requests(6);
        // sender pauses until all results are in
        wait_for_results();
        random_requests(6);
        set_size(pcc_pkg::SIZE_W'($urandom_range(3, 15)));
        random_requests(10);
        wait_for_results();
    endtask

    // sink holds off while requests keep coming, so the input side has to stall
    task automatic test_sink_hold();
        sender_idling = 1'b0;
        hold_pending  = 1'b1;
        random_requests(8);
        wait_for_results();
        sender_idling = 1'b1;
    endtask

    task automatic test_back_to_back();
        sender_idling = 1'b0;
        sink_idling   = 1'b0;
        set_size(5'd16);
        random_requests(10);
        wait_for_results();
    endtask

    initial begin : result_sink
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                m_tready <= 1'b1;
            end else if (sink_idling && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        perm_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (perm_results.size() == 0) begin
                $error("result with nothing awaited: tdata %h last %b", m_tdata, m_tlast);
                failures++;
            end else begin
                want = perm_results.pop_front();
                if (m_tdata[0] !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_tdata[0]);
                    failures++;
                end
                if (m_tdata[5:1] !== want.data) begin
                    $error("data: expected %0d, got %0d", want.data, m_tdata[5:1]);
                    failures++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, m_tlast);
                    failures++;
                end
            end
        end
    end

    initial begin : watchdog
        #(8 * 400000);
        $display("Mismatches found");
        $finish;
    end

    initial begin : sequencer
        for (int i = 0; i < pcc_pkg::MAX_SIZE_DEF; i++) begin
            main_model[i]    = pcc_pkg::FIELD_W'(i + 1);
            operand_model[i] = pcc_pkg::FIELD_W'(i + 1);
        end
        size_model = pcc_pkg::SIZE_RST;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_state();
        test_rejected_writes();
        test_compose();
        test_stale_and_broken();
        test_random_sizes();
        test_sink_hold();
        test_back_to_back();
        wait_for_results();
        repeat (60) @(posedge aclk);
        if (failures == 0 && perm_results.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire

FILE: permutation_compose_and_cycles.f
src/pcc_pkg.sv
src/permutation_compose_and_cycles.sv
bench/tb_permutation_compose_and_cycles.sv
